>>> rtl/core/per_client_fixed_window_rate_limiter_defines.svh
// Assertion macros used by the rate limiter table (pcrl_table).
`ifndef PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH
`define PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define PCRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcrl assertion failed");

// next-cycle implication
`define PCRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcrl assertion failed");

`endif

>>> rtl/core/pcrl_pkg.sv
// Types and constants of the per-client fixed-window rate limiter.
package pcrl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int EVICT_W       = 5;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [1:0] REG_WINDOW       = 2'd0;
   localparam logic [1:0] REG_MAX_REQUESTS = 2'd1;
   localparam logic [1:0] REG_SWEEP_PERIOD = 2'd2;

   localparam logic [30:0] WINDOW_RESET       = 31'd60000;
   localparam logic [15:0] MAX_REQUESTS_RESET = 16'd60;
   localparam logic [31:0] SWEEP_RESET        = 32'd60000;

   typedef enum logic {
      ACT_REQUEST = 1'b0,
      ACT_TICK    = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] client_ip;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic               allowed;
      logic               untracked;
      logic [EVICT_W-1:0] evicted_count;
   } rsp_type;

   typedef struct packed {
      logic [30:0] window_ms;
      logic [15:0] max_requests;
      logic [31:0] sweep_period_ms;
   } cfg_type;

endpackage

>>> rtl/core/per_client_fixed_window_rate_limiter.sv
// Top level of the per-client fixed-window rate limiter.
//
//   channel  direction  payload    handshake
//   req_     in         req_type   req_valid / req_ready
//   rsp_     out        rsp_type   rsp_valid / rsp_ready
//   csr_     in/out     32-bit     APB write at psel & penable & pwrite
//
// One request per cycle unless a response is held; responses register in out_ff.
// The whole table (16 entry comparators and age checks) is resolved combinationally.
// A held response stalls the input register, which then drops req_ready.
// Synchronous reset clears the table valid bits, the sweep time and the pipe.
module per_client_fixed_window_rate_limiter import pcrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   req_type in_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type res;
   cfg_type cfg_ff, cfg_in;
   logic    advance, csr_wr;
   logic [1:0] csr_idx;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   pcrl_table u_table (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .res   (res)
   );

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_WINDOW:       cfg_in.window_ms       = csr_pwdata[30:0];
            REG_MAX_REQUESTS: cfg_in.max_requests    = csr_pwdata[15:0];
            REG_SWEEP_PERIOD: cfg_in.sweep_period_ms = csr_pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WINDOW:       csr_prdata = {1'b0, cfg_ff.window_ms};
         REG_MAX_REQUESTS: csr_prdata = {16'd0, cfg_ff.max_requests};
         REG_SWEEP_PERIOD: csr_prdata = cfg_ff.sweep_period_ms;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms       <= WINDOW_RESET;
         cfg_ff.max_requests    <= MAX_REQUESTS_RESET;
         cfg_ff.sweep_period_ms <= SWEEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/pcrl_table.sv
// Client table: lookup, window check, insert and sweep in one pass.
`include "per_client_fixed_window_rate_limiter_defines.svh"

module pcrl_table import pcrl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type res
);

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]              addr_ff  [TABLE_ENTRIES];
   logic [31:0]              start_ff [TABLE_ENTRIES];
   logic [15:0]              count_ff [TABLE_ENTRIES];
   logic [31:0]              last_sweep_ff, last_sweep_in;

   logic [31:0]              age [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] match, expired, at_limit, stale;
   logic                     hit_any, free_any;
   logic [IDX_W-1:0]         hit_idx, free_idx;
   logic                     hit_expired, hit_limit;
   logic                     is_req, sweep_due;
   logic [31:0]              limit;

   assign is_req    = (item.action == ACT_REQUEST);
   assign limit     = {cfg.window_ms, 1'b0};
   assign sweep_due = ((item.now_ms - last_sweep_ff) >= cfg.sweep_period_ms);

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         age[i]      = item.now_ms - start_ff[i];
         match[i]    = valid_ff[i] && (addr_ff[i] == item.client_ip);
         expired[i]  = (age[i] >= {1'b0, cfg.window_ms});
         at_limit[i] = (count_ff[i] >= cfg.max_requests);
         stale[i]    = valid_ff[i] && (age[i] >= limit);
      end
   end

   // lowest matching entry, lowest free entry
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit_expired = expired[hit_idx];
   assign hit_limit   = at_limit[hit_idx];

   always_comb begin
      res = '0;
      if (is_req) begin
         if (!hit_any) begin
            res.allowed   = 1'b1;
            res.untracked = !free_any;
         end else begin
            res.allowed = hit_expired || !hit_limit;
         end
      end else if (sweep_due) begin
         res.evicted_count = EVICT_W'($countones(stale));
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      last_sweep_in = last_sweep_ff;
      if (step) begin
         if (is_req) begin
            if (!hit_any && free_any) begin
               valid_in[free_idx] = 1'b1;
            end
         end else if (sweep_due) begin
            valid_in      = valid_ff & ~stale;
            last_sweep_in = item.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         last_sweep_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         last_sweep_ff <= last_sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && is_req) begin
         if (hit_any) begin
            if (hit_expired) begin
               start_ff[hit_idx] <= item.now_ms;
               count_ff[hit_idx] <= 16'd1;
            end else if (!hit_limit) begin
               count_ff[hit_idx] <= count_ff[hit_idx] + 16'd1;
            end
         end else if (free_any) begin
            addr_ff[free_idx]  <= item.client_ip;
            start_ff[free_idx] <= item.now_ms;
            count_ff[free_idx] <= 16'd1;
         end
      end
   end

   `PCRL_ASSERT_NOW(a_untracked_full, clock, reset, step && res.untracked, &valid_ff)
   `PCRL_ASSERT_NEXT(a_req_no_shrink, clock, reset, step && is_req,
      $countones(valid_ff) >= $past($countones(valid_ff)))
   `PCRL_ASSERT_NEXT(a_evict_matches, clock, reset, step && !is_req,
      $countones(valid_ff) == $past($countones(valid_ff)) - $past(res.evicted_count))
   `PCRL_ASSERT_NOW(a_tick_no_admit, clock, reset, !is_req,
      !res.allowed && !res.untracked)

endmodule

>>> tb/pcrl_admission_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rate limiter: mirrors the client table and checks every response.
module pcrl_admission_checker import pcrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    outstanding
);

   logic [30:0] window_len;
   logic [15:0] req_limit;
   logic [31:0] sweep_gap;
   logic        slot_used   [TABLE_ENTRIES];
   logic [31:0] slot_client [TABLE_ENTRIES];
   logic [31:0] slot_start  [TABLE_ENTRIES];
   logic [15:0] slot_hits   [TABLE_ENTRIES];
   logic [31:0] swept_at;
   rsp_type     expected_verdicts[$];
   rsp_type     want;

   function automatic rsp_type admit_or_sweep(input req_type item);
      rsp_type     verdict;
      int          hit;
      int          spare;
      logic [31:0] age;
      logic [31:0] limit;
      logic [4:0]  freed;
      verdict = '0;
      hit     = -1;
      spare   = -1;
      if (item.action == ACT_REQUEST) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_client[i] == item.client_ip)
                  hit = i;
            end else if (spare < 0) begin
               spare = i;
            end
         end
         verdict.allowed = 1'b1;
         if (hit < 0) begin
            if (spare < 0) begin
               verdict.untracked = 1'b1;
            end else begin
               slot_used[spare]   = 1'b1;
               slot_client[spare] = item.client_ip;
               slot_start[spare]  = item.now_ms;
               slot_hits[spare]   = 16'd1;
            end
         end else begin
            age = item.now_ms - slot_start[hit];
            if (age >= {1'b0, window_len}) begin
               slot_start[hit] = item.now_ms;
               slot_hits[hit]  = 16'd1;
            end else if (slot_hits[hit] >= req_limit) begin
               verdict.allowed = 1'b0;
            end else begin
               slot_hits[hit] = slot_hits[hit] + 16'd1;
            end
         end
      end else begin
         age = item.now_ms - swept_at;
         if (age >= sweep_gap) begin
            limit = {window_len, 1'b0};
            freed = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               age = item.now_ms - slot_start[i];
               if (slot_used[i] && age >= limit) begin
                  slot_used[i] = 1'b0;
                  freed        = freed + 5'd1;
               end
            end
            swept_at              = item.now_ms;
            verdict.evicted_count = freed;
         end
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         window_len = WINDOW_RESET;
         req_limit  = MAX_REQUESTS_RESET;
         sweep_gap  = SWEEP_RESET;
         swept_at   = '0;
         foreach (slot_used[i])
            slot_used[i] = 1'b0;
         expected_verdicts.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_WINDOW:       window_len = csr_pwdata[30:0];
               REG_MAX_REQUESTS: req_limit  = csr_pwdata[15:0];
               REG_SWEEP_PERIOD: sweep_gap  = csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response %p", $realtime, rsp_data);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.allowed !== want.allowed ||
                   rsp_data.untracked !== want.untracked ||
                   rsp_data.evicted_count !== want.evicted_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: response expected %p, got %p", $realtime, want, rsp_data);
               end
            end
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(admit_or_sweep(req_data));
      end
      outstanding <= expected_verdicts.size();
   end

endmodule

>>> tb/per_client_fixed_window_rate_limiter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the rate limiter: clock, reset, CSR writes, request stimulus, response back-pressure and verdict.
module per_client_fixed_window_rate_limiter_tb;
   import pcrl_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int         POOL_SIZE  = 20;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    outstanding;

   bit          calm     = 1'b0;
   int          idle_pct = 0;
   logic [31:0] now_cursor;
   logic [31:0] client_pool[POOL_SIZE];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   per_client_fixed_window_rate_limiter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pcrl_admission_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input action_type act, input logic [31:0] ip,
                            input logic [31:0] now);
      req_valid <= 1'b1;
      req_data  <= '{action: act, client_ip: ip, now_ms: now};
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // hold off until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input logic [31:0] window,
                            input logic [31:0] limit, input logic [31:0] sweep,
                            input logic [31:0] step_max, input int idle);
      int          pick;
      logic [31:0] ip;
      drain();
      csr_write(REG_WINDOW, window);
      csr_write(REG_MAX_REQUESTS, limit);
      csr_write(REG_SWEEP_PERIOD, sweep);
      idle_pct = idle;
      foreach (client_pool[i])
         client_pool[i] = $urandom;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_item(action_type'($urandom_range(0, 1)), $urandom, $urandom);
         end else begin
            now_cursor = now_cursor + $urandom_range(0, step_max);
            if (pick < 18)
               ip = $urandom;
            else if (pick < 60)
               ip = client_pool[$urandom_range(0, 3)];
            else if (pick < 92)
               ip = client_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               ip = $urandom;
            send_item(pick < 18 ? ACT_TICK : ACT_REQUEST, ip, now_cursor);
         end
         if (k == count / 2)
            drain();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      now_cursor  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: limit, window restart, wrap, sweeps, full table
      csr_write(REG_WINDOW, 32'd10);
      csr_write(REG_MAX_REQUESTS, 32'd2);
      csr_write(REG_SWEEP_PERIOD, 32'd5);
      idle_pct = 30;
      send_item(ACT_REQUEST, 32'h0000_0000, 32'd0);
      send_item(ACT_REQUEST, 32'h0000_0000, 32'd1);
      send_item(ACT_REQUEST, 32'h0000_0000, 32'd2);
      send_item(ACT_REQUEST, 32'h0000_0000, 32'd10);
      send_item(ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_REQUEST, 32'hFFFF_FFFF, 32'd5);
      send_item(ACT_TICK, 32'hFFFF_FFFF, 32'd3);
      send_item(ACT_TICK, 32'h0000_0000, 32'd30);
      for (int i = 1; i <= TABLE_ENTRIES + 1; i++)
         send_item(ACT_REQUEST, {i[3:0], 28'h5A5_A5A5} ^ i, 32'd40);
      send_item(ACT_TICK, 32'h1234_5678, 32'd100);

      run_phase(130, 32'd50, 32'd3, 32'd40, 32'd4, 30);
      run_phase(120, 32'd1, 32'd1, 32'd1, 32'd1, 0);
      drain();
      csr_write(REG_UNUSED, $urandom);
      run_phase(100, 32'd0, 32'd0, 32'd0, 32'd3, 40);
      run_phase(120, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000, 20);
      now_cursor = 32'hFFFF_FF00;
      run_phase(150, 32'd200, 32'd5, 32'd100, 32'd10, 25);
      calm = 1'b1;
      run_phase(130, 32'd30, 32'd2, 32'd20, 32'd3, 0);

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("per_client_fixed_window_rate_limiter: match");
      else
         $display("per_client_fixed_window_rate_limiter: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("per_client_fixed_window_rate_limiter: mismatch");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pcrl_pkg.sv
rtl/core/pcrl_table.sv
rtl/core/per_client_fixed_window_rate_limiter.sv
tb/pcrl_admission_checker.sv
tb/per_client_fixed_window_rate_limiter_tb.sv
